@@ hdl/sata_pkg.sv @@
`default_nettype none

package sata_pkg;

  // Largest atlas dimension; register values above it are treated as this.
  localparam logic [14:0] ATLAS_LIMIT = 15'd16384;

  // Request codes.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic CFG_ATLAS_HEIGHT = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ATLAS_FULL = 2'd1;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;
  localparam logic [1:0] STATUS_TOO_WIDE   = 2'd3;

  // One entry of the row table.
  typedef struct packed {
    logic [13:0] top;
    logic [14:0] tall;
    logic [14:0] filled;
  } row_t;

  // Operands of the row fit check.
  typedef struct packed {
    logic [14:0] tile_w;
    logic [14:0] tile_h;
    logic [14:0] atlas_w;
  } fit_req_t;

  // Outcome of the row fit check.
  typedef struct packed {
    logic        fit;
    logic [14:0] new_filled;
  } fit_res_t;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_NEW  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

endpackage

`default_nettype wire

@@ hdl/sata_ram.sv @@
`default_nettype none

module sata_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/sata_fit_unit.sv @@
`default_nettype none

module sata_fit_unit
  import sata_pkg::*;
(
  input  row_t     row_i,
  input  fit_req_t req_i,
  output fit_res_t res_o
);

  logic [15:0] end_x;

  // A row fits when it is tall enough and its fill point plus the tile
  // width stays within the atlas width.
  assign end_x = {1'b0, row_i.filled} + {1'b0, req_i.tile_w};

  always_comb begin
    res_o.fit        = (row_i.tall >= req_i.tile_h) && (end_x <= {1'b0, req_i.atlas_w});
    res_o.new_filled = end_x[14:0];
  end

endmodule

`default_nettype wire

@@ hdl/shelf_atlas_tile_allocator_unit.sv @@
`default_nettype none

// Shelf allocator for rectangular tiles in an atlas. An allocate request is
// placed in the first open row that is tall enough and has room left; if
// none fits, a new row is opened below the last one. Every request yields
// exactly one result carrying a status, the tile position, the running pixel
// total and the row count. The block works on one request at a time, and the
// row table scan sets the time it takes. The scan reads one row per cycle from
// a single read port of the row table memory, and each check takes place in the
// cycle after its read. A tile that fits a row, or that opens a new one, then
// passes through the multiply, accumulate and done states before it is loaded
// into the output register. A tile refused for a full table or a full atlas
// goes from the new-row state straight to the done state; clear requests and
// tiles that are rejected on their size go there straight from idle. The next
// request is taken in the cycle after the result has been loaded, and a
// result that waits at a stalled output delays that load. The next request is
// accepted while a result still waits to be taken at the output register. The
// row table needs no clearing pass after reset.
module shelf_atlas_tile_allocator_unit
  import sata_pkg::*;
#(
  parameter int MaxRows = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [14:0] tile_width_i,
  input  logic [14:0] tile_height_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [13:0] pos_x_o,
  output logic [13:0] pos_y_o,
  output logic [28:0] used_pixels_o,
  output logic [6:0]  rows_in_use_o
);

  localparam int CntW  = $clog2(MaxRows + 1);
  localparam int AddrW = (MaxRows > 1) ? $clog2(MaxRows) : 1;

  // Configuration registers.
  logic [14:0] atlas_w_q, atlas_h_q;
  logic [14:0] aw_eff, ah_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= 15'd4096;
      atlas_h_q <= 15'd4096;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ATLAS_WIDTH) begin
        atlas_w_q <= cfg_data_i;
      end else begin
        atlas_h_q <= cfg_data_i;
      end
    end
  end

  // Oversized atlas values act as the atlas limit.
  assign aw_eff = (atlas_w_q > ATLAS_LIMIT) ? ATLAS_LIMIT : atlas_w_q;
  assign ah_eff = (atlas_h_q > ATLAS_LIMIT) ? ATLAS_LIMIT : atlas_h_q;

  state_e         state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] chk_idx_q, chk_idx_d;
  logic           pend_q, pend_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [28:0]    pix_q, pix_d;
  logic [14:0]    bottom_q, bottom_d;
  logic [14:0]    w_q, w_d, h_q, h_d;
  logic [14:0]    tall_q, tall_d;
  logic [13:0]    x_q, x_d, y_q, y_d;
  logic [1:0]     stat_q, stat_d;
  logic [29:0]    prod_q, prod_d;

  logic           out_vld_q, out_vld_d;
  logic [1:0]     out_stat_q, out_stat_d;
  logic [13:0]    out_x_q, out_x_d, out_y_q, out_y_d;
  logic [28:0]    out_pix_q, out_pix_d;
  logic [6:0]     out_rows_q, out_rows_d;

  // Row table memory.
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  row_t             ram_wdata;
  row_t             rd_row;
  logic [$bits(row_t)-1:0] ram_rdata;

  sata_ram #(
    .Width ($bits(row_t)),
    .Depth (MaxRows)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_row = ram_rdata;

  // Shared row fit check.
  fit_req_t fit_req;
  fit_res_t fit_res;

  assign fit_req = '{tile_w: w_q, tile_h: h_q, atlas_w: aw_eff};

  sata_fit_unit u_fit (
    .row_i (rd_row),
    .req_i (fit_req),
    .res_o (fit_res)
  );

  logic        in_acc;
  logic        load_out;
  logic [15:0] new_end_y;
  logic [CntW+6:0] cnt_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign new_end_y  = {1'b0, bottom_q} + {1'b0, h_q};
  assign cnt_ext    = {7'd0, cnt_q};
  assign load_out   = (state_q == ST_DONE) && (!out_vld_q || !out_stall_i);

  // Sequencer: scan rows one per cycle, open a new row, multiply, accumulate.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    chk_idx_d = chk_idx_q;
    pend_d    = 1'b0;
    cnt_d     = cnt_q;
    pix_d     = pix_q;
    bottom_d  = bottom_q;
    w_d       = w_q;
    h_d       = h_q;
    tall_d    = tall_q;
    x_d       = x_q;
    y_d       = y_q;
    stat_d    = stat_q;
    prod_d    = prod_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = chk_idx_q[AddrW-1:0];
    ram_raddr = idx_q[AddrW-1:0];
    ram_wdata = '{top: rd_row.top, tall: rd_row.tall, filled: fit_res.new_filled};

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          w_d = tile_width_i;
          h_d = tile_height_i;
          x_d = 14'd0;
          y_d = 14'd0;
          if (req_type_i == REQ_CLEAR) begin
            cnt_d    = '0;
            pix_d    = '0;
            bottom_d = '0;
            stat_d   = STATUS_OK;
            state_d  = ST_DONE;
          end else if (tile_width_i == 15'd0 || tile_height_i == 15'd0 ||
                       tile_width_i > aw_eff) begin
            stat_d  = STATUS_TOO_WIDE;
            state_d = ST_DONE;
          end else if (cnt_q == '0) begin
            state_d = ST_NEW;
          end else begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read while checking the row read last cycle.
        if (idx_q < cnt_q) begin
          ram_re    = 1'b1;
          pend_d    = 1'b1;
          chk_idx_d = idx_q;
          idx_d     = idx_q + 1'b1;
        end
        if (pend_q) begin
          if (fit_res.fit) begin
            ram_we  = 1'b1;
            tall_d  = rd_row.tall;
            x_d     = rd_row.filled[13:0];
            y_d     = rd_row.top;
            stat_d  = STATUS_OK;
            pend_d  = 1'b0;
            state_d = ST_MUL;
          end else if ((chk_idx_q + 1'b1) == cnt_q) begin
            pend_d  = 1'b0;
            state_d = ST_NEW;
          end
        end
      end

      ST_NEW: begin
        // Open a new row below the last one when table and atlas allow it.
        if (cnt_q >= CntW'(MaxRows)) begin
          stat_d  = STATUS_TABLE_FULL;
          state_d = ST_DONE;
        end else if (new_end_y > {1'b0, ah_eff}) begin
          stat_d  = STATUS_ATLAS_FULL;
          state_d = ST_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[AddrW-1:0];
          ram_wdata = '{top: bottom_q[13:0], tall: h_q, filled: w_q};
          cnt_d     = cnt_q + 1'b1;
          bottom_d  = new_end_y[14:0];
          tall_d    = h_q;
          x_d       = 14'd0;
          y_d       = bottom_q[13:0];
          stat_d    = STATUS_OK;
          state_d   = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_d  = 30'(w_q) * 30'(tall_q);
        state_d = ST_ACC;
      end

      ST_ACC: begin
        pix_d   = pix_q + prod_q[28:0];
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: loads a finished result once the slot is free.
  always_comb begin
    out_vld_d  = out_vld_q;
    out_stat_d = out_stat_q;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    out_pix_d  = out_pix_q;
    out_rows_d = out_rows_q;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d  = 1'b1;
      out_stat_d = stat_q;
      out_x_d    = x_q;
      out_y_d    = y_q;
      out_pix_d  = pix_q;
      out_rows_d = cnt_ext[6:0];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      chk_idx_q <= '0;
      pend_q    <= 1'b0;
      cnt_q     <= '0;
      pix_q     <= '0;
      bottom_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      chk_idx_q <= chk_idx_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      pix_q     <= pix_d;
      bottom_q  <= bottom_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    h_q        <= h_d;
    tall_q     <= tall_d;
    x_q        <= x_d;
    y_q        <= y_d;
    stat_q     <= stat_d;
    prod_q     <= prod_d;
    out_stat_q <= out_stat_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_pix_q  <= out_pix_d;
    out_rows_q <= out_rows_d;
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_stat_q;
  assign pos_x_o       = out_x_q;
  assign pos_y_o       = out_y_q;
  assign used_pixels_o = out_pix_q;
  assign rows_in_use_o = out_rows_q;

endmodule

`default_nettype wire
